// File: rtl/mbrp_pkg.sv
// Shared types and constants for the multibulk request parser.
// No dependencies; imported by mbrp_step, multibulk_request_parser, multibulk_parse_checker and the testbench.

package mbrp_pkg;

   // default field widths for lengths and element counts
   localparam int LENGTH_BITS_DEFAULT = 30;
   localparam int COUNT_BITS_DEFAULT  = 16;

   // decimal accumulator width and its saturation value
   localparam int ACC_W = 31;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   // configuration register widths and indexes
   localparam int MAX_COUNT_W  = 16;
   localparam int MAX_LENGTH_W = 30;
   localparam int CSR_DATA_W   = 30;
   localparam int CSR_INDEX_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH = 1'b1;

   // reset values of the configuration registers
   localparam logic [MAX_COUNT_W-1:0]  MAX_COUNT_RESET  = 16'd1024;
   localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RESET = 30'd536870912;

   localparam int ARG_W = 16;

   // protocol characters
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // parse phase
   typedef enum logic [3:0] {
      PH_STAR       = 4'd0,
      PH_COUNT      = 4'd1,
      PH_COUNT_SKIP = 4'd2,
      PH_DOLLAR     = 4'd3,
      PH_LEN        = 4'd4,
      PH_LEN_SKIP   = 4'd5,
      PH_PAYLOAD    = 4'd6,
      PH_TRAIL1     = 4'd7,
      PH_TRAIL2     = 4'd8
   } phase_type;

   // result word kind
   typedef enum logic [2:0] {
      K_FRAME = 3'd0,
      K_NAME  = 3'd1,
      K_ARG   = 3'd2,
      K_DONE  = 3'd3,
      K_ERR   = 3'd4
   } kind_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NO_STAR    = 3'd0,
      ERR_NO_DOLLAR  = 3'd1,
      ERR_BAD_DIGIT  = 3'd2,
      ERR_LEN_LARGE  = 3'd3,
      ERR_COUNT_BAD  = 3'd4
   } err_type;

   // one result word
   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      logic [ARG_W-1:0] arg_index;
      logic             last_of_field;
      err_type          error_code;
   } result_type;

endpackage

// File: rtl/mbrp_step.sv
// Next-state and result logic of the multibulk request parser for one byte.
// Depends on mbrp_pkg; instantiated by multibulk_request_parser.

module mbrp_step import mbrp_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
   parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
) (
   input  phase_type               phase,
   input  logic [ACC_W-1:0]        acc,
   input  logic [COUNT_BITS-1:0]   elements_left,
   input  logic [LENGTH_BITS-1:0]  bytes_left,
   input  logic [ARG_W-1:0]        current_arg,
   input  logic                    in_name,
   input  logic [7:0]              in_byte,
   input  logic [MAX_COUNT_W-1:0]  max_count,
   input  logic [MAX_LENGTH_W-1:0] max_length,
   output phase_type               phase_in,
   output logic [ACC_W-1:0]        acc_in,
   output logic [COUNT_BITS-1:0]   elements_left_in,
   output logic [LENGTH_BITS-1:0]  bytes_left_in,
   output logic [ARG_W-1:0]        current_arg_in,
   output logic                    in_name_in,
   output result_type              result
);

   localparam int PROD_W = ACC_W + 4;

   logic                   is_digit;
   logic [3:0]             digit_byte;
   logic [PROD_W-1:0]      acc_x10;
   logic [ACC_W-1:0]       acc_next_digit;
   logic                   count_bad;
   logic                   length_bad;
   logic [LENGTH_BITS-1:0] bytes_dec;
   logic [COUNT_BITS-1:0]  elements_dec;
   logic [7:0]             name_byte;

   // digit decode and saturating times-ten accumulate
   assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
   assign digit_byte = 4'(in_byte - CH_ZERO);
   assign acc_x10    = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                       + {{(PROD_W-4){1'b0}}, digit_byte};
   assign acc_next_digit = (acc_x10 > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_x10[ACC_W-1:0];

   // limit checks on the finished number
   assign count_bad  = (acc == '0)
                       || (acc > {{(ACC_W-MAX_COUNT_W){1'b0}}, max_count})
                       || ((acc >> COUNT_BITS) != '0);
   assign length_bad = (acc > {{(ACC_W-MAX_LENGTH_W){1'b0}}, max_length})
                       || ((acc >> LENGTH_BITS) != '0);

   assign bytes_dec    = bytes_left - LENGTH_BITS'(1);
   assign elements_dec = elements_left - COUNT_BITS'(1);

   // lowercase for command name bytes
   assign name_byte = ((in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_Z)) ?
                      (in_byte + CASE_OFFSET) : in_byte;

   // phase machine for one byte
   always_comb begin
      phase_in         = phase;
      acc_in           = acc;
      elements_left_in = elements_left;
      bytes_left_in    = bytes_left;
      current_arg_in   = current_arg;
      in_name_in       = in_name;
      result           = '{kind: K_FRAME, data: 8'h00, arg_index: '0,
                           last_of_field: 1'b0, error_code: ERR_NO_STAR};
      unique case (phase)
         PH_STAR: begin
            acc_in = '0;
            if (in_byte != CH_STAR) begin
               phase_in          = PH_STAR;
               result.kind       = K_ERR;
               result.error_code = ERR_NO_STAR;
            end else begin
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            if (is_digit) begin
               acc_in = acc_next_digit;
            end else if (in_byte != CH_CR) begin
               phase_in          = PH_STAR;
               acc_in            = '0;
               result.kind       = K_ERR;
               result.error_code = ERR_BAD_DIGIT;
            end else if (count_bad) begin
               phase_in          = PH_STAR;
               acc_in            = '0;
               result.kind       = K_ERR;
               result.error_code = ERR_COUNT_BAD;
            end else begin
               elements_left_in = COUNT_BITS'(acc);
               acc_in           = '0;
               in_name_in       = 1'b1;
               current_arg_in   = '0;
               phase_in         = PH_COUNT_SKIP;
            end
         end
         PH_COUNT_SKIP: begin
            phase_in = PH_DOLLAR;
         end
         PH_DOLLAR: begin
            acc_in = '0;
            if (in_byte != CH_DOLLAR) begin
               phase_in          = PH_STAR;
               result.kind       = K_ERR;
               result.error_code = ERR_NO_DOLLAR;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if (is_digit) begin
               acc_in = acc_next_digit;
            end else if (in_byte != CH_CR) begin
               phase_in          = PH_STAR;
               acc_in            = '0;
               result.kind       = K_ERR;
               result.error_code = ERR_BAD_DIGIT;
            end else if (length_bad) begin
               phase_in          = PH_STAR;
               acc_in            = '0;
               result.kind       = K_ERR;
               result.error_code = ERR_LEN_LARGE;
            end else begin
               bytes_left_in = LENGTH_BITS'(acc);
               acc_in        = '0;
               phase_in      = PH_LEN_SKIP;
            end
         end
         PH_LEN_SKIP: begin
            phase_in = (bytes_left == '0) ? PH_TRAIL1 : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            bytes_left_in        = bytes_dec;
            result.last_of_field = (bytes_dec == '0);
            if (bytes_dec == '0) begin
               phase_in = PH_TRAIL1;
            end
            if (in_name) begin
               result.kind = K_NAME;
               result.data = name_byte;
            end else begin
               result.kind      = K_ARG;
               result.data      = in_byte;
               result.arg_index = current_arg;
            end
         end
         PH_TRAIL1: begin
            phase_in = PH_TRAIL2;
         end
         PH_TRAIL2: begin
            elements_left_in = elements_dec;
            if (in_name) begin
               in_name_in = 1'b0;
            end else begin
               current_arg_in = current_arg + ARG_W'(1);
            end
            if (elements_dec == '0) begin
               phase_in    = PH_STAR;
               result.kind = K_DONE;
            end else begin
               phase_in = PH_DOLLAR;
            end
         end
         default: begin
            phase_in = PH_STAR;
         end
      endcase
   end

endmodule

// File: rtl/multibulk_request_parser.sv
// Multibulk request parser: one raw byte in, one result word out.
// Latency: the result of a byte is valid in the cycle after the byte is taken.
// Throughput: one byte per cycle; the parse state and a single result register
// turn over together, and a new byte is taken whenever that register is empty
// or being drained. Synchronous reset returns the parser to expecting '*'
// and loads the default element count and bulk length limits.
// Depends on mbrp_pkg and mbrp_step.

module multibulk_request_parser import mbrp_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
   parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // byte input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_kind,
   output logic [7:0]             rsp_data,
   output logic [ARG_W-1:0]       rsp_arg_index,
   output logic                   rsp_last_of_field,
   output logic [2:0]             rsp_error_code,
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   phase_type               phase_ff, phase_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [COUNT_BITS-1:0]   elements_left_ff, elements_left_in;
   logic [LENGTH_BITS-1:0]  bytes_left_ff, bytes_left_in;
   logic [ARG_W-1:0]        current_arg_ff, current_arg_in;
   logic                    in_name_ff, in_name_in;
   logic [MAX_COUNT_W-1:0]  max_count_ff;
   logic [MAX_LENGTH_W-1:0] max_length_ff;
   logic                    rsp_valid_ff;
   result_type              result_ff, result_in;
   logic                    accept;

   // take a word when the result register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   mbrp_step #(
      .LENGTH_BITS (LENGTH_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_step (
      .phase            (phase_ff),
      .acc              (acc_ff),
      .elements_left    (elements_left_ff),
      .bytes_left       (bytes_left_ff),
      .current_arg      (current_arg_ff),
      .in_name          (in_name_ff),
      .in_byte          (req_in_byte),
      .max_count        (max_count_ff),
      .max_length       (max_length_ff),
      .phase_in         (phase_in),
      .acc_in           (acc_in),
      .elements_left_in (elements_left_in),
      .bytes_left_in    (bytes_left_in),
      .current_arg_in   (current_arg_in),
      .in_name_in       (in_name_in),
      .result           (result_in)
   );

   // parse state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_STAR;
         acc_ff           <= '0;
         elements_left_ff <= '0;
         bytes_left_ff    <= '0;
         current_arg_ff   <= '0;
         in_name_ff       <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff         <= phase_in;
            acc_ff           <= acc_in;
            elements_left_ff <= elements_left_in;
            bytes_left_ff    <= bytes_left_in;
            current_arg_ff   <= current_arg_in;
            in_name_ff       <= in_name_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff  <= MAX_COUNT_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_COUNT:  max_count_ff  <= csr_wdata[MAX_COUNT_W-1:0];
            CSR_MAX_LENGTH: max_length_ff <= csr_wdata[MAX_LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = result_ff.kind;
   assign rsp_data          = result_ff.data;
   assign rsp_arg_index     = result_ff.arg_index;
   assign rsp_last_of_field = result_ff.last_of_field;
   assign rsp_error_code    = result_ff.error_code;

endmodule

// File: test/multibulk_parse_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the multibulk request parser: tracks the parse state from the
// accepted bytes, predicts one result word per byte and checks the words in order.
// Depends on mbrp_pkg.

module multibulk_parse_checker import mbrp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [2:0]             rsp_kind,
   input  logic [7:0]             rsp_data,
   input  logic [ARG_W-1:0]       rsp_arg_index,
   input  logic                   rsp_last_of_field,
   input  logic [2:0]             rsp_error_code,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     backlog,
   output int                     words_seen,
   output int                     requests_done,
   output int                     faults_seen
);

   localparam logic [ACC_W-1:0] COUNT_FIELD_MAX  = ACC_W'((64'd1 << COUNT_BITS_DEFAULT) - 1);
   localparam logic [ACC_W-1:0] LENGTH_FIELD_MAX = ACC_W'((64'd1 << LENGTH_BITS_DEFAULT) - 1);
   localparam int DECIMAL_BASE = 10;
   localparam int PRINT_LIMIT  = 20;

   // tracked parse state and limit registers
   phase_type                      parse_phase;
   logic [ACC_W-1:0]               number_acc;
   logic [COUNT_BITS_DEFAULT-1:0]  elems_left;
   logic [LENGTH_BITS_DEFAULT-1:0] payload_left;
   logic [ARG_W-1:0]               arg_no;
   logic                           name_field;
   logic [MAX_COUNT_W-1:0]         limit_count;
   logic [MAX_LENGTH_W-1:0]        limit_length;

   // expected result words, oldest first
   result_type expected_words[$];
   result_type want;

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t: mismatch on word %0d: %s", $time, words_seen, what);
   endtask

   // protocol violation: back to waiting for a star
   function automatic result_type fault(input err_type code);
      result_type w;
      parse_phase = PH_STAR;
      number_acc  = '0;
      w = '0;
      w.kind = K_ERR;
      w.error_code = code;
      return w;
   endfunction

   // decimal accumulate, saturating
   function automatic void accumulate(input logic [7:0] b);
      logic [63:0] wide;
      wide = 64'(number_acc) * DECIMAL_BASE + 64'(b - CH_ZERO);
      number_acc = (wide > 64'(ACC_MAX)) ? ACC_MAX : wide[ACC_W-1:0];
   endfunction

   // advance the parse by one byte and return the word it should produce
   function automatic result_type parse_byte(input logic [7:0] b);
      result_type w;
      logic       is_digit;
      w = '0;
      w.kind = K_FRAME;
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      case (parse_phase)
         PH_STAR: begin
            if (b != CH_STAR) return fault(ERR_NO_STAR);
            number_acc = '0;
            parse_phase = PH_COUNT;
         end
         PH_COUNT: begin
            if (is_digit) begin
               accumulate(b);
            end else if (b != CH_CR) begin
               return fault(ERR_BAD_DIGIT);
            end else if (number_acc == '0 || number_acc > limit_count ||
                         number_acc > COUNT_FIELD_MAX) begin
               return fault(ERR_COUNT_BAD);
            end else begin
               elems_left  = number_acc[COUNT_BITS_DEFAULT-1:0];
               number_acc  = '0;
               name_field  = 1'b1;
               arg_no      = '0;
               parse_phase = PH_COUNT_SKIP;
            end
         end
         PH_COUNT_SKIP: parse_phase = PH_DOLLAR;
         PH_DOLLAR: begin
            if (b != CH_DOLLAR) return fault(ERR_NO_DOLLAR);
            number_acc = '0;
            parse_phase = PH_LEN;
         end
         PH_LEN: begin
            if (is_digit) begin
               accumulate(b);
            end else if (b != CH_CR) begin
               return fault(ERR_BAD_DIGIT);
            end else if (number_acc > limit_length || number_acc > LENGTH_FIELD_MAX) begin
               return fault(ERR_LEN_LARGE);
            end else begin
               payload_left = number_acc[LENGTH_BITS_DEFAULT-1:0];
               number_acc   = '0;
               parse_phase  = PH_LEN_SKIP;
            end
         end
         PH_LEN_SKIP: parse_phase = (payload_left == '0) ? PH_TRAIL1 : PH_PAYLOAD;
         PH_PAYLOAD: begin
            payload_left = payload_left - 1'b1;
            w.last_of_field = (payload_left == '0);
            if (w.last_of_field) parse_phase = PH_TRAIL1;
            // the command name is folded to lower case, arguments pass as they are
            if (name_field) begin
               w.kind = K_NAME;
               w.data = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
            end else begin
               w.kind = K_ARG;
               w.data = b;
               w.arg_index = arg_no;
            end
         end
         PH_TRAIL1: parse_phase = PH_TRAIL2;
         PH_TRAIL2: begin
            elems_left = elems_left - 1'b1;
            if (name_field) name_field = 1'b0;
            else arg_no = arg_no + 1'b1;
            if (elems_left == '0) begin
               parse_phase = PH_STAR;
               w.kind = K_DONE;
            end else begin
               parse_phase = PH_DOLLAR;
            end
         end
         default: parse_phase = PH_STAR;
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         parse_phase  = PH_STAR;
         number_acc   = '0;
         elems_left   = '0;
         payload_left = '0;
         arg_no       = '0;
         name_field   = 1'b1;
         limit_count  = MAX_COUNT_RESET;
         limit_length = MAX_LENGTH_RESET;
         expected_words.delete();
      end else begin
         // result side: compare with the oldest expected word
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
               flag_mismatch($sformatf("word of kind %0d with nothing expected", rsp_kind));
            end else begin
               want = expected_words.pop_front();
               if (rsp_kind !== want.kind)
                  flag_mismatch($sformatf("kind got %0d want %0d", rsp_kind, want.kind));
               if (rsp_data !== want.data)
                  flag_mismatch($sformatf("data got %02h want %02h", rsp_data, want.data));
               if (rsp_arg_index !== want.arg_index)
                  flag_mismatch($sformatf("arg_index got %0d want %0d",
                                          rsp_arg_index, want.arg_index));
               if (rsp_last_of_field !== want.last_of_field)
                  flag_mismatch($sformatf("last_of_field got %0b want %0b",
                                          rsp_last_of_field, want.last_of_field));
               if (rsp_error_code !== want.error_code)
                  flag_mismatch($sformatf("error_code got %0d want %0d",
                                          rsp_error_code, want.error_code));
               if (want.kind == K_DONE) requests_done++;
               if (want.kind == K_ERR) faults_seen++;
            end
         end
         // limit register writes
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_COUNT:  limit_count  = csr_wdata[MAX_COUNT_W-1:0];
               CSR_MAX_LENGTH: limit_length = csr_wdata[MAX_LENGTH_W-1:0];
               default: ;
            endcase
         end
         // byte side: predict the word for each accepted byte
         if (req_valid && req_ready)
            expected_words = {expected_words, parse_byte(req_in_byte)};
      end
      backlog <= expected_words.size();
   end

endmodule

// File: test/tb_multibulk_request_parser.sv
`timescale 1ns / 100ps
// Testbench top for the multibulk request parser: clock, reset, byte stream,
// limit register writes and the verdict. Depends on mbrp_pkg,
// multibulk_request_parser and multibulk_parse_checker.

module tb_multibulk_request_parser;
   import mbrp_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int PHASES      = 6;
   localparam int PHASE_BYTES = 330;
   localparam logic [7:0] LINE_FEED = 8'h0A;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_in_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic [2:0]             rsp_kind;
   logic [7:0]             rsp_data;
   logic [ARG_W-1:0]       rsp_arg_index;
   logic                   rsp_last_of_field;
   logic [2:0]             rsp_error_code;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_MAX_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   int mismatches, backlog, words_seen, requests_done, faults_seen;

   // stimulus state
   bit          idle_on     = 1'b0;
   bit          active_idle = 1'b0;
   int          stall_left  = 0;
   int unsigned bytes_sent  = 0;
   int unsigned settings_applied = 0;
   int unsigned cur_max_count = MAX_COUNT_RESET;
   int unsigned cur_max_len   = MAX_LENGTH_RESET;
   logic [7:0]  pending_bytes[$];

   // limit settings per phase, extremes included
   int unsigned limit_counts[PHASES]  = '{1024, 1, 65535, 3, 2, 8};
   int unsigned limit_lengths[PHASES] = '{536870912, 0, 1073741823, 5, 12, 3};

   always #(HALF_PERIOD) clock = ~clock;

   multibulk_request_parser u_dut (.*);

   multibulk_parse_checker u_checker (.*);

   // run limit
   initial begin
      #(10_000_000);
      $display("multibulk_request_parser test failed");
      $finish;
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) stall_left--;
      else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 9);
      rsp_ready <= (stall_left == 0);
   end

   // append one byte to the outgoing stream
   function automatic void queue_byte(input logic [7:0] b);
      pending_bytes = {pending_bytes, b};
   endfunction

   // one byte, with an optional idle gap before it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_pending();
      while (pending_bytes.size() != 0) send_byte(pending_bytes.pop_front());
   endtask

   // stop sending and let every expected word drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic apply_limits(input int unsigned count_limit, input int unsigned length_limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_COUNT;
      csr_wdata <= CSR_DATA_W'(count_limit);
      @(posedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_wdata <= CSR_DATA_W'(length_limit);
      @(posedge clock);
      csr_we <= 1'b0;
      cur_max_count = count_limit;
      cur_max_len   = length_limit;
      settings_applied++;
   endtask

   // skipped bytes are mostly line feeds, sometimes anything
   function automatic logic [7:0] filler();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : LINE_FEED;
   endfunction

   function automatic logic [7:0] name_char();
      case ($urandom_range(0, 3))
         0:       return CH_UPPER_A + 8'($urandom_range(0, 25));
         1:       return CH_UPPER_A + CASE_OFFSET + 8'($urandom_range(0, 25));
         2:       return 8'($urandom_range(0, 255));
         default: return CH_UPPER_Z - 8'($urandom_range(0, 25));
      endcase
   endfunction

   function automatic void add_text(input string s);
      foreach (s[i]) queue_byte(s[i]);
   endfunction

   // marker, decimal number, CR and the skipped byte
   function automatic void add_header(input logic [7:0] marker, input string digits);
      queue_byte(marker);
      add_text(digits);
      queue_byte(CH_CR);
      queue_byte(filler());
   endfunction

   function automatic void add_trailer();
      queue_byte(filler());
      queue_byte(filler());
   endfunction

   // requests right at and just over the current limits
   task automatic boundary_requests();
      add_header(CH_STAR, $sformatf("%0d", cur_max_count));
      queue_byte(CH_STAR);
      add_header(CH_STAR, $sformatf("%0d", cur_max_count + 1));
      add_header(CH_STAR, "1");
      add_header(CH_DOLLAR, $sformatf("%0d", longint'(cur_max_len) + 1));
      if (cur_max_len <= 24) begin
         add_header(CH_STAR, "1");
         add_header(CH_DOLLAR, $sformatf("%0d", cur_max_len));
         repeat (cur_max_len) queue_byte(name_char());
         add_trailer();
      end
      send_pending();
   endtask

   // mostly well-formed requests with random content, some noise and damage
   task automatic random_request();
      int unsigned     pick;
      int unsigned     cap;
      longint unsigned count;
      longint unsigned len;
      string           digits;
      idle_on = active_idle && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
      end else begin
         if (pick < 7) begin
            count  = 0;
            digits = (pick == 5) ? "" : "00";
         end else if (pick < 10) begin
            count  = cur_max_count + 1;
            digits = $sformatf("%0d", count);
         end else if (pick == 10) begin
            count  = 64'd99999999999;
            digits = "99999999999";
         end else begin
            cap = (pick < 85) ? 4 : 12;
            if (cap > cur_max_count) cap = cur_max_count;
            count  = $urandom_range(1, cap);
            digits = $sformatf("%0d", count);
            if ($urandom_range(0, 7) == 0) digits = {"0", digits};
         end
         add_header(CH_STAR, digits);
         if (count >= 1 && count <= cur_max_count) begin
            for (longint unsigned i = 0; i < count; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 3) begin
                  len = longint'(cur_max_len) + 1;
               end else begin
                  cap = (pick < 80) ? 6 : 24;
                  if (cap > cur_max_len) cap = cur_max_len;
                  len = $urandom_range(0, cap);
               end
               add_header(CH_DOLLAR, $sformatf("%0d", len));
               if (len > cur_max_len) break;
               repeat (len)
                  queue_byte((i == 0) ? name_char() : 8'($urandom_range(0, 255)));
               add_trailer();
            end
         end
         // damage a few requests: one byte overwritten or the tail cut off
         pick = $urandom_range(0, 99);
         if (pick < 8)
            pending_bytes[$urandom_range(0, pending_bytes.size() - 1)] =
               8'($urandom_range(0, 255));
         else if (pick < 12)
            repeat ($urandom_range(1, pending_bytes.size() - 1)) void'(pending_bytes.pop_back());
      end
      send_pending();
   endtask

   initial begin
      int unsigned target;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bad start bytes at both extremes
      queue_byte(8'h00);
      queue_byte(8'hFF);
      // full request: mixed-case name, empty argument, extreme argument bytes
      add_header(CH_STAR, "3");
      add_header(CH_DOLLAR, "4");
      add_text("Az@[");
      add_trailer();
      add_header(CH_DOLLAR, "0");
      add_trailer();
      add_header(CH_DOLLAR, "2");
      queue_byte(8'h00);
      queue_byte(8'hFF);
      add_trailer();
      // empty count, bad digit, missing dollar, saturating length
      add_header(CH_STAR, "");
      add_text("*1a");
      add_header(CH_STAR, "1");
      add_text("#");
      add_header(CH_STAR, "1");
      add_header(CH_DOLLAR, "99999999999");
      // leading zero count with an empty length
      add_header(CH_STAR, "01");
      add_header(CH_DOLLAR, "");
      add_trailer();
      send_pending();

      // random phases, one limit setting each; the last runs without idling
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         apply_limits(limit_counts[p], limit_lengths[p]);
         active_idle = (p != PHASES - 1);
         idle_on = active_idle;
         boundary_requests();
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) random_request();
      end
      idle_on = 1'b0;
      wait_idle();

      $display("covered %0d bytes and %0d result words over %0d limit settings",
               bytes_sent, words_seen, settings_applied);
      $display("requests completed: %0d, protocol errors flagged: %0d",
               requests_done, faults_seen);
      if (mismatches == 0) begin
         $display("multibulk_request_parser test passed");
      end else begin
         $display("multibulk_request_parser test failed");
      end
      $finish;
   end

endmodule
